>>> rtl/core/pba_pkg.sv
// ---------------------------------------------------------------------------
// pba_pkg - page bitmap allocator package
// Sizes, derived widths and request codes for the page bitmap allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

	// number of physical pages tracked by the used-bit map
	localparam int PAGE_COUNT = 128;

	// field widths fixed by the interface
	localparam int KIND_W  = 2;
	localparam int COUNT_W = 8;
	localparam int PAGE_W  = 7;
	localparam int AVAIL_W = 8;
	localparam int RES_W   = 8;

	// widths that follow from the page count
	localparam int PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int FC_W  = $clog2(PAGE_COUNT + 1);
	localparam int CMP_W = ((PAGE_W > PG_W) ? PAGE_W : PG_W) + 1;
	localparam int AW    = ((FC_W > RES_W) ? FC_W : RES_W) + 1;

	// request codes
	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RESERVE = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

endpackage

`default_nettype wire

>>> rtl/core/page_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// page_bitmap_allocator - lowest-free page allocator with reservation
// Used-bit map, free page count and reserved count; one result per request.
// ---------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid/in_stall   | kind, count, page
//  out     | out_valid/out_stall | page_index, found, refused, available
//
//  One request is accepted per cycle unless the result stalls; it passes through
//  the input register, then the result register. The map, free count and reserved
//  count update as a request leaves the input register, so the next request
//  sees them at once; the lowest free page comes from a priority encoder.
//  Reset clears the map (all pages free) and the reserved count at once.
//  A stalled result holds the input register, which then stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none

module page_bitmap_allocator
	import pba_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [COUNT_W-1:0] count,
	input  wire logic [PAGE_W-1:0]  page,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic [PAGE_W-1:0]  page_index,
	output      logic               found,
	output      logic               refused,
	output      logic [AVAIL_W-1:0] available
);

	// input register
	logic               valid_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic [COUNT_W-1:0] count_s1;
	logic [PAGE_W-1:0]  page_s1;

	// allocator state
	logic [PAGE_COUNT-1:0] used_map_q;
	logic [FC_W-1:0]       free_count_q;
	logic [RES_W-1:0]      reserved_q;

	// result register
	logic               out_valid_q;
	logic [PAGE_W-1:0]  page_index_q;
	logic               found_q;
	logic               refused_q;
	logic [AVAIL_W-1:0] available_q;

	// datapath
	logic                  adv;
	logic                  s1_fire;
	logic                  alloc_hit;
	logic [PG_W-1:0]       alloc_idx;
	logic [CMP_W-1:0]      alloc_idx_wide;
	logic [CMP_W-1:0]      page_wide;
	logic                  page_in_range;
	logic [PG_W-1:0]       page_idx;
	logic [AW-1:0]         avail_now;
	logic [RES_W:0]        res_sum;
	logic                  res_refuse;
	logic [PAGE_COUNT-1:0] used_next;
	logic [FC_W-1:0]       free_next;
	logic [RES_W-1:0]      res_next;
	logic [AW-1:0]         avail_next;
	logic [PAGE_W-1:0]     idx_res;
	logic                  found_res;
	logic                  refused_res;
	logic [AVAIL_W-1:0]    avail_res;

	// handshake
	assign adv      = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	// lowest free page
	always_comb begin
		alloc_hit = 1'b0;
		alloc_idx = '0;
		for (int i = PAGE_COUNT - 1; i >= 0; i--) begin
			if (!used_map_q[i]) begin
				alloc_hit = 1'b1;
				alloc_idx = PG_W'(i);
			end
		end
	end

	assign alloc_idx_wide = CMP_W'(alloc_idx);
	assign page_wide      = CMP_W'(page_s1);
	assign page_in_range  = page_wide < CMP_W'(PAGE_COUNT);
	assign page_idx       = PG_W'(page_wide);

	// available before this request, and the reserve check
	assign avail_now  = (AW'(free_count_q) > AW'(reserved_q)) ?
	                    (AW'(free_count_q) - AW'(reserved_q)) : '0;
	assign res_sum    = {1'b0, reserved_q} + {1'b0, count_s1};
	assign res_refuse = (AW'(count_s1) > avail_now) || (res_sum > (RES_W+1)'(255));

	// next state and result fields
	always_comb begin
		used_next   = used_map_q;
		free_next   = free_count_q;
		res_next    = reserved_q;
		idx_res     = '0;
		found_res   = 1'b0;
		refused_res = 1'b0;
		case (kind_s1)
			KIND_ALLOC: begin
				if (alloc_hit) begin
					used_next[alloc_idx] = 1'b1;
					free_next            = free_count_q - FC_W'(1);
					idx_res              = alloc_idx_wide[PAGE_W-1:0];
					found_res            = 1'b1;
					if (reserved_q != '0) begin
						res_next = reserved_q - RES_W'(1);
					end
				end
			end
			KIND_RESERVE: begin
				if (res_refuse) begin
					refused_res = 1'b1;
				end else begin
					res_next = res_sum[RES_W-1:0];
				end
			end
			KIND_RELEASE: begin
				if (page_in_range && used_map_q[page_idx]) begin
					used_next[page_idx] = 1'b0;
					free_next           = free_count_q + FC_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// available after this request, held at the field maximum
	assign avail_next = (AW'(free_next) > AW'(res_next)) ?
	                    (AW'(free_next) - AW'(res_next)) : '0;
	assign avail_res  = (avail_next > AW'(255)) ? AVAIL_W'(255) : avail_next[AVAIL_W-1:0];

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1  <= kind;
			count_s1 <= count;
			page_s1  <= page;
		end
	end

	// allocator state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_map_q   <= '0;
			free_count_q <= FC_W'(PAGE_COUNT);
			reserved_q   <= '0;
		end else if (s1_fire) begin
			used_map_q   <= used_next;
			free_count_q <= free_next;
			reserved_q   <= res_next;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			page_index_q <= idx_res;
			found_q      <= found_res;
			refused_q    <= refused_res;
			available_q  <= avail_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign page_index = page_index_q;
	assign found      = found_q;
	assign refused    = refused_q;
	assign available  = available_q;

`ifndef SYNTHESIS
	// free count tracks the map
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(free_count_q) + 32'($countones(used_map_q))) == 32'(PAGE_COUNT))
		else $error("free count out of step with used map");

	// a result never reports both a page and a refusal
	a_found_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> !refused_q)
		else $error("found and refused both set");

	// an allocated page is marked used afterwards
	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && (kind_s1 == KIND_ALLOC) && alloc_hit |=> used_map_q[$past(alloc_idx)])
		else $error("allocated page not marked used");

	// input stalls only behind a held request
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with no held request");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
// ---------------------------------------------------------------------------
// tb - testbench for page_bitmap_allocator
// Sends allocate, reserve, release and unknown-kind transactions through the
// valid/stall handshake. A behavioral copy of the page map and the reserved
// count predicts each result, which is checked field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import pba_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
	localparam int QUIET_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RESERVED_MAX    = 255;

	typedef struct packed {
		logic [PAGE_W-1:0]  page_index;
		logic               found;
		logic               refused;
		logic [AVAIL_W-1:0] available;
	} grant_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [KIND_W-1:0]  kind      = KIND_ALLOC;
	logic [COUNT_W-1:0] count     = '0;
	logic [PAGE_W-1:0]  page      = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [PAGE_W-1:0]  page_index;
	logic               found;
	logic               refused;
	logic [AVAIL_W-1:0] available;

	// predicted allocator state
	logic [PAGE_COUNT-1:0] page_used      = '0;
	int unsigned           pages_reserved = 0;
	grant_t                expected_grants[$];

	// idling and hold-off control
	int src_idle_pct  = 0;
	int dst_idle_pct  = 0;
	int hold_len      = 0;
	int hold_seq      = 0;
	int hold_seq_seen = 0;
	int hold_left     = 0;

	// run statistics
	int error_count  = 0;
	int quiet_cycles = 0;
	int n_requests   = 0;
	int n_results    = 0;
	int n_granted    = 0;
	int n_denied     = 0;
	int n_refused    = 0;

	page_bitmap_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.count      (count),
		.page       (page),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.page_index (page_index),
		.found      (found),
		.refused    (refused),
		.available  (available)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// free pages minus reserved pages, floored at zero and held at 255
	function automatic int unsigned pages_available();
		int unsigned free_cnt;
		int unsigned avail;
		free_cnt = $countones(~page_used);
		avail = (free_cnt > pages_reserved) ? free_cnt - pages_reserved : 0;
		if (avail > 255)
			avail = 255;
		return avail;
	endfunction

	// apply one request to the predicted state and return its grant
	function automatic grant_t predict_grant(input logic [KIND_W-1:0] k,
			input logic [COUNT_W-1:0] c, input logic [PAGE_W-1:0] p);
		grant_t g;
		g = '0;
		case (k)
			KIND_ALLOC: begin
				for (int i = 0; i < PAGE_COUNT; i++) begin
					if (!page_used[i] && !g.found) begin
						page_used[i] = 1'b1;
						g.page_index = PAGE_W'(i);
						g.found = 1'b1;
						if (pages_reserved > 0)
							pages_reserved--;
					end
				end
				if (g.found)
					n_granted++;
				else
					n_denied++;
			end
			KIND_RESERVE: begin
				if (c > pages_available() || pages_reserved + c > RESERVED_MAX) begin
					g.refused = 1'b1;
					n_refused++;
				end else begin
					pages_reserved += c;
				end
			end
			KIND_RELEASE: begin
				if (p < PAGE_COUNT)
					page_used[p] = 1'b0;
			end
			default: ;
		endcase
		g.available = AVAIL_W'(pages_available());
		return g;
	endfunction

	// offer one transaction, record its grant once it is taken
	task automatic send_request(input logic [KIND_W-1:0] k,
			input logic [COUNT_W-1:0] c, input logic [PAGE_W-1:0] p);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		count    <= c;
		page     <= p;
		do @(negedge clk); while (in_stall);
		expected_grants.push_back(predict_grant(k, c, p));
		n_requests++;
		@(posedge clk);
	endtask

	// stop offering and wait for every outstanding grant
	task automatic wait_for_grants();
		in_valid <= 1'b0;
		while (expected_grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int src_pct, input int dst_pct);
		in_valid <= 1'b0;
		@(negedge clk);
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
		@(posedge clk);
	endtask

	// ask the result side to stall for a fixed stretch
	task automatic hold_results(input int len);
		in_valid <= 1'b0;
		@(negedge clk);
		hold_len = len;
		hold_seq++;
		@(posedge clk);
	endtask

	// result side stall, random or held off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seq_seen) begin
			hold_seq_seen <= hold_seq;
			hold_left     <= hold_len;
			out_stall     <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < dst_idle_pct);
		end
	end

	// compare each result transaction with the oldest grant
	always @(negedge clk) begin
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_grants.size() == 0) begin
				$error("unexpected result: page_index %0d found %0b refused %0b available %0d",
					page_index, found, refused, available);
				error_count++;
			end else begin
				want = expected_grants.pop_front();
				n_results++;
				if (page_index !== want.page_index) begin
					$error("page_index: expected %0d, got %0d", want.page_index, page_index);
					error_count++;
				end
				if (found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, found);
					error_count++;
				end
				if (refused !== want.refused) begin
					$error("refused: expected %0b, got %0b", want.refused, refused);
					error_count++;
				end
				if (available !== want.available) begin
					$error("available: expected %0d, got %0d", want.available, available);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	// fresh block reports every page available
	task automatic test_reset_state();
		send_request(KIND_UNKNOWN, '1, '1);
	endtask

	// each kind and its corner cases on a nearly empty map
	task automatic test_each_kind();
		send_request(KIND_ALLOC, '0, '0);
		send_request(KIND_ALLOC, '0, '0);
		send_request(KIND_RESERVE, 8'd0, '0);
		send_request(KIND_RESERVE, 8'd126, '0);
		send_request(KIND_RESERVE, 8'd1, '0);
		send_request(KIND_RESERVE, 8'd255, '0);
		send_request(KIND_ALLOC, '0, '0);
		send_request(KIND_RELEASE, '0, 7'd1);
		send_request(KIND_RELEASE, '0, 7'd1);
		send_request(KIND_RELEASE, '0, 7'd127);
		send_request(KIND_ALLOC, '1, '1);
		send_request(KIND_RESERVE, 8'd0, '1);
		send_request(KIND_RELEASE, '1, 7'd0);
		send_request(KIND_RELEASE, '0, 7'd2);
		send_request(KIND_ALLOC, '1, '1);
		send_request(KIND_RESERVE, 8'h80, '0);
		send_request(KIND_UNKNOWN, '0, '0);
	endtask

	// fill the whole map, allocate past the end, then free part of it
	task automatic test_full_map();
		while (page_used != '1)
			send_request(KIND_ALLOC, COUNT_W'($urandom), PAGE_W'($urandom));
		send_request(KIND_ALLOC, '0, '0);
		send_request(KIND_ALLOC, '1, '1);
		send_request(KIND_RESERVE, 8'd1, '0);
		send_request(KIND_RELEASE, '0, PAGE_W'($urandom));
		send_request(KIND_RESERVE, 8'd1, '0);
		send_request(KIND_ALLOC, '0, '0);
		send_request(KIND_ALLOC, '0, '0);
		repeat (40)
			send_request(KIND_RELEASE, COUNT_W'($urandom), PAGE_W'($urandom));
	endtask

	// random mix weighted toward meaningful requests
	task automatic test_random_mix(input int n);
		int unsigned sel;
		int unsigned start;
		logic [COUNT_W-1:0] c;
		logic [PAGE_W-1:0] p;
		repeat (n) begin
			sel = $urandom_range(99);
			c = COUNT_W'($urandom);
			p = PAGE_W'($urandom);
			if (sel < 40) begin
				send_request(KIND_ALLOC, c, p);
			end else if (sel < 75) begin
				// mostly free a page that is in use
				if (page_used != '0 && $urandom_range(3) != 0) begin
					start = $urandom_range(PAGE_COUNT - 1);
					for (int j = 0; j < PAGE_COUNT; j++) begin
						if (page_used[(start + j) % PAGE_COUNT]) begin
							p = PAGE_W'((start + j) % PAGE_COUNT);
							break;
						end
					end
				end
				send_request(KIND_RELEASE, c, p);
			end else if (sel < 95) begin
				// mostly sizes around the available count
				if ($urandom_range(4) != 0)
					c = COUNT_W'($urandom_range(pages_available() + 1));
				send_request(KIND_RESERVE, c, p);
			end else begin
				send_request(KIND_UNKNOWN, c, p);
			end
		end
	endtask

	// long result stall while requests keep coming, so the input backs up
	task automatic test_output_hold_off();
		set_idling(0, 0);
		hold_results(HOLD_OFF_CYCLES);
		test_random_mix(16);
	endtask

	// a few requests, then a full stop until all results are back
	task automatic test_drained_pause();
		test_random_mix(6);
		wait_for_grants();
		test_random_mix(6);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(31, 72);
		test_reset_state();
		test_each_kind();
		test_full_map();

		set_idling(72, 31);
		test_random_mix(180);
		test_output_hold_off();

		set_idling(0, 0);
		test_drained_pause();
		test_random_mix(170);

		wait_for_grants();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests sent, %0d results checked, %0d errors",
			n_requests, n_results, error_count);
		$display("tb: %0d pages granted, %0d allocations on a full map, %0d reserves refused",
			n_granted, n_denied, n_refused);
		if (error_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
